// ===== hdl/srl_pkg.sv =====
package srl_pkg;

  // parse phases of the record walker
  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_ABORT = 4'd1,
    PH_TYPE  = 4'd2,
    PH_SKIP  = 4'd3,
    PH_ENDW  = 4'd4,
    PH_COUNT = 4'd5,
    PH_ADDR  = 4'd6,
    PH_DATA  = 4'd7,
    PH_SUM   = 4'd8,
    PH_EOL   = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_END     = 3'd1,
    KIND_UNKNOWN = 3'd2,
    KIND_ABORT   = 3'd3,
    KIND_RANGE   = 3'd4
  } kind_e;

  // what the record type character after 's' means
  typedef enum logic [1:0] {
    REC_HEADER = 2'd0,
    REC_DATA   = 2'd1,
    REC_END    = 2'd2,
    REC_OTHER  = 2'd3
  } rec_e;

  typedef struct packed {
    logic [3:0] nib;
    logic       is_cr;
    logic       is_eol;
    logic       is_dot;
    logic       is_s;
    rec_e       rec;
    logic [2:0] addr_bytes;
  } chr_t;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_PROG_START = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_WORK_BASE  = 1'd1;

  localparam logic [31:0] ProgStartReset = 32'h5000_0000;
  localparam logic [31:0] WorkBaseReset  = 32'h5000_0000;

  localparam logic [31:0] DramLow   = 32'h4000_0000;
  localparam logic [31:0] DramHigh  = 32'hC000_0000;
  localparam logic [31:0] SramLow   = 32'hE630_0000;
  localparam logic [31:0] SramLast  = 32'hE635_FFFF;
  localparam logic [31:0] AddrOnes  = 32'hFFFF_FFFF;
  localparam logic [31:0] AddrZero  = 32'h0000_0000;

  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChLowS = 8'h73;
  localparam logic [7:0] ChUpS  = 8'h53;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

// ===== hdl/srecord_stream_loader.sv =====
// S-record loader: takes one ASCII character per transaction and sustains one character
// per clock cycle unless the output stalls. A character is classified on entry and
// parked in a two-entry queue; the record walker then parses one character per cycle,
// and a result (a data write, a load or unknown-record end with min and max address, an
// abort, or a range error) sits in an output register that is reloaded in the cycle
// it is taken; its character passes the queue first. The walker's single state update
// per cycle sets the rate. Configuration writes pass the config and window registers.
module srecord_stream_loader
  import srl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [31:0]        write_address_o,
  output logic [7:0]         write_data_o,
  output logic [31:0]        min_address_o,
  output logic [31:0]        max_address_o
);

  logic [31:0] prog_start_q;
  logic [31:0] work_base_q;
  logic        push;
  chr_t        push_data;
  logic        full;
  logic        q_valid;
  chr_t        q_data;
  logic        pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_start_q <= ProgStartReset;
      work_base_q  <= WorkBaseReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROG_START: prog_start_q <= cfg_data_i;
        CFG_WORK_BASE:  work_base_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srl_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_in_i   (char_in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  srl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  srl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prog_start_i    (prog_start_q),
    .work_base_i     (work_base_q),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .min_address_o   (min_address_o),
    .max_address_o   (max_address_o)
  );

endmodule

// ===== hdl/srl_front.sv =====
module srl_front
  import srl_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       full_i,
  output logic       push_o,
  output chr_t       push_data_o
);

  chr_t cls;

  always_comb begin
    cls = '0;
    if (char_in_i >= 8'h30 && char_in_i <= 8'h39) begin
      cls.nib = 4'(char_in_i - 8'h30);
    end else if (char_in_i >= 8'h41 && char_in_i <= 8'h46) begin
      cls.nib = 4'(char_in_i - 8'h41 + 8'd10);
    end else if (char_in_i >= 8'h61 && char_in_i <= 8'h66) begin
      cls.nib = 4'(char_in_i - 8'h61 + 8'd10);
    end
    cls.is_cr  = (char_in_i == ChCr);
    cls.is_eol = (char_in_i == ChCr) || (char_in_i == ChLf);
    cls.is_dot = (char_in_i == ChDot);
    cls.is_s   = (char_in_i == ChLowS) || (char_in_i == ChUpS);
    // record type digit: '1'..'3' give 2..4 address bytes
    if (char_in_i == 8'h30) begin
      cls.rec = REC_HEADER;
    end else if (char_in_i >= 8'h31 && char_in_i <= 8'h33) begin
      cls.rec = REC_DATA;
    end else if (char_in_i >= 8'h37 && char_in_i <= 8'h39) begin
      cls.rec = REC_END;
    end else begin
      cls.rec = REC_OTHER;
    end
    cls.addr_bytes = {1'b0, char_in_i[1:0]} + 3'd1;
  end

  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;
  assign push_data_o = cls;

endmodule

// ===== hdl/srl_fifo.sv =====
module srl_fifo
  import srl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  chr_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output chr_t data_o
);

  chr_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/srl_back.sv =====
module srl_back
  import srl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] prog_start_i,
  input  logic [31:0] work_base_i,
  input  logic        q_valid_i,
  input  chr_t        q_data_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [31:0] min_address_o,
  output logic [31:0] max_address_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  ab_q, ab_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] low_q, low_d;
  logic [31:0] high_q, high_d;
  kind_e       endk_q, endk_d;

  logic [31:0] offset_q;
  logic        in_range_q;
  logic        in_range;

  logic        ov_q, ov_d;
  kind_e       ok_q, ok_d;
  logic [31:0] owa_q, owa_d;
  logic [7:0]  owd_q, owd_d;
  logic [31:0] omin_q, omin_d;
  logic [31:0] omax_q, omax_d;

  logic        take;
  logic        restart;
  logic        res;
  kind_e       res_kind;
  logic [31:0] res_wa;
  logic [7:0]  res_wd;
  logic [31:0] res_min;
  logic [31:0] res_max;
  logic [31:0] acc_sh;
  logic [3:0]  idx_inc;
  logic [31:0] addr_new;
  logic [7:0]  ab_plus;
  logic [7:0]  left_dec;

  // window check, offset regs; user moves config only while idle, unenforced
  always_comb begin
    in_range = ((prog_start_i >= DramLow) && (prog_start_i < work_base_i)) ||
               ((prog_start_i >= work_base_i) && (prog_start_i < DramHigh)) ||
               ((prog_start_i >= SramLow) && (prog_start_i <= SramLast));
  end

  assign take     = q_valid_i && (!ov_q || out_ready_i);
  assign pop_o    = take;
  assign acc_sh   = {acc_q[27:0], q_data_i.nib};
  assign idx_inc  = idx_q + 4'd1;
  assign addr_new = acc_sh + offset_q;
  assign ab_plus  = {5'd0, ab_q} + 8'd1;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    ab_d     = ab_q;
    left_d   = left_q;
    acc_d    = acc_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    low_d    = low_q;
    high_d   = high_q;
    endk_d   = endk_q;
    restart  = 1'b0;
    res      = 1'b0;
    res_kind = KIND_WRITE;
    res_wa   = AddrZero;
    res_wd   = 8'd0;
    res_min  = AddrZero;
    res_max  = AddrZero;
    if (take) begin
      if (!in_range_q) begin
        res      = 1'b1;
        res_kind = KIND_RANGE;
      end else begin
        case (phase_q)
          PH_ABORT: begin
            if (q_data_i.is_cr) begin
              restart  = 1'b1;
              res      = 1'b1;
              res_kind = KIND_ABORT;
            end
          end
          PH_TYPE: begin
            case (q_data_i.rec)
              REC_HEADER: phase_d = PH_SKIP;
              REC_DATA: begin
                ab_d    = q_data_i.addr_bytes;
                acc_d   = '0;
                idx_d   = '0;
                phase_d = PH_COUNT;
              end
              REC_END: begin
                endk_d  = KIND_END;
                phase_d = PH_ENDW;
              end
              default: begin
                endk_d  = KIND_UNKNOWN;
                phase_d = PH_ENDW;
              end
            endcase
          end
          PH_SKIP: begin
            if (q_data_i.is_eol) begin
              phase_d = PH_HUNT;
            end
          end
          PH_ENDW: begin
            if (q_data_i.is_eol) begin
              restart  = 1'b1;
              res      = 1'b1;
              res_kind = endk_q;
              res_min  = low_q;
              res_max  = high_q;
            end
          end
          PH_COUNT: begin
            acc_d = acc_sh;
            idx_d = idx_inc;
            if (idx_inc >= 4'd2) begin
              idx_d   = '0;
              left_d  = (acc_sh[7:0] > ab_plus) ? acc_sh[7:0] - ab_plus : 8'd0;
              acc_d   = '0;
              phase_d = PH_ADDR;
            end
          end
          PH_ADDR: begin
            acc_d = acc_sh;
            idx_d = idx_inc;
            if (idx_inc >= {ab_q, 1'b0}) begin
              idx_d = '0;
              cur_d = addr_new;
              if (addr_new < low_q) begin
                low_d = addr_new;
              end
              acc_d   = '0;
              phase_d = (left_q != 8'd0) ? PH_DATA : PH_SUM;
            end
          end
          PH_DATA: begin
            acc_d = acc_sh;
            idx_d = idx_inc;
            if (idx_inc >= 4'd2) begin
              idx_d = '0;
              acc_d = '0;
              if (cur_q > high_q) begin
                high_d = cur_q;
              end
              cur_d  = cur_q + 32'd1;
              left_d = left_dec;
              if (left_dec == 8'd0) begin
                phase_d = PH_SUM;
              end
              res      = 1'b1;
              res_kind = KIND_WRITE;
              res_wa   = cur_q;
              res_wd   = acc_sh[7:0];
            end
          end
          PH_SUM: begin
            acc_d = acc_sh;
            idx_d = idx_inc;
            if (idx_inc >= 4'd2) begin
              idx_d   = '0;
              acc_d   = '0;
              phase_d = PH_EOL;
            end
          end
          PH_EOL: phase_d = PH_HUNT;
          default: begin
            if (q_data_i.is_dot) begin
              phase_d = PH_ABORT;
            end else if (q_data_i.is_s) begin
              phase_d = PH_TYPE;
            end else begin
              phase_d = PH_HUNT;
            end
          end
        endcase
      end
    end
    if (restart) begin
      phase_d = PH_HUNT;
      ab_d    = '0;
      left_d  = '0;
      acc_d   = '0;
      idx_d   = '0;
      cur_d   = AddrZero;
      low_d   = AddrOnes;
      high_d  = AddrZero;
      endk_d  = KIND_WRITE;
    end
  end

  // output register, refilled in the cycle it is taken
  always_comb begin
    ov_d   = ov_q;
    ok_d   = ok_q;
    owa_d  = owa_q;
    owd_d  = owd_q;
    omin_d = omin_q;
    omax_d = omax_q;
    if (res) begin
      ov_d   = 1'b1;
      ok_d   = res_kind;
      owa_d  = res_wa;
      owd_d  = res_wd;
      omin_d = res_min;
      omax_d = res_max;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      ab_q       <= '0;
      left_q     <= '0;
      acc_q      <= '0;
      idx_q      <= '0;
      cur_q      <= AddrZero;
      low_q      <= AddrOnes;
      high_q     <= AddrZero;
      endk_q     <= KIND_WRITE;
      offset_q   <= WorkBaseReset - ProgStartReset;
      in_range_q <= 1'b1;
      ov_q       <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      ab_q       <= ab_d;
      left_q     <= left_d;
      acc_q      <= acc_d;
      idx_q      <= idx_d;
      cur_q      <= cur_d;
      low_q      <= low_d;
      high_q     <= high_d;
      endk_q     <= endk_d;
      offset_q   <= work_base_i - prog_start_i;
      in_range_q <= in_range;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= ok_d;
    owa_q  <= owa_d;
    owd_q  <= owd_d;
    omin_q <= omin_d;
    omax_q <= omax_d;
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = ok_q;
  assign write_address_o = owa_q;
  assign write_data_o    = owd_q;
  assign min_address_o   = omin_q;
  assign max_address_o   = omax_q;

endmodule
